/* hdl/tilalu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilalu_pkg
// Shared types, opcodes and the type-mask helper function of the typed IL integer ALU.
// ----------------------------------------------------------------------------
package tilalu_pkg;

	localparam int DW         = 64;
	localparam int HW         = DW / 2;
	localparam int DIV_STAGES = DW;
	// Levels from the second arithmetic register to the divider output register.
	localparam int SIDE_DELAY = DIV_STAGES - 1;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_OR  = 4'd1,
		OP_XOR = 4'd2,
		OP_ADD = 4'd3,
		OP_SUB = 4'd4,
		OP_MUL = 4'd5,
		OP_DIV = 4'd6,
		OP_GT  = 4'd7,
		OP_GE  = 4'd8,
		OP_EQ  = 4'd9,
		OP_NE  = 4'd10,
		OP_LT  = 4'd11,
		OP_LE  = 4'd12
	} op_t;

	localparam logic [2:0] TYPE_BOOL  = 3'd0;
	localparam logic [2:0] TYPE_BYTE  = 3'd1;
	localparam logic [2:0] TYPE_WORD  = 3'd2;
	localparam logic [2:0] TYPE_DWORD = 3'd3;

	typedef struct packed {
		logic [3:0]    func;
		logic          is_bool;
		logic [DW-1:0] mask;
	} ctrl_t;

	function automatic logic [DW-1:0] type_mask(input logic [2:0] dtype);
		logic [DW-1:0] m;
		unique case (dtype)
			TYPE_BYTE:  m = DW'(64'hFF);
			TYPE_WORD:  m = DW'(64'hFFFF);
			TYPE_DWORD: m = DW'(64'hFFFF_FFFF);
			default:    m = '1;
		endcase
		return m;
	endfunction

endpackage

/* hdl/tilalu_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilalu_prep
// First stage: applies the negate modifier and cuts both operands to the type.
// ----------------------------------------------------------------------------
module tilalu_prep import tilalu_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [3:0]    func,
	input  logic          negate_b,
	input  logic [2:0]    data_type,
	input  logic [DW-1:0] operand_a,
	input  logic [DW-1:0] operand_b,
	output logic [DW-1:0] a_s1,
	output logic [DW-1:0] b_s1,
	output ctrl_t         ctrl_s1
);

	logic [DW-1:0] a_c, b_c, b_n, m;
	logic          is_bool;

	always_comb begin
		is_bool = (data_type == TYPE_BOOL);
		m       = type_mask(data_type);
		b_n     = negate_b ? ~operand_b : operand_b;
		if (is_bool) begin
			// A bool operand is its truth value; negation is the logical inverse.
			a_c = DW'(|operand_a);
			b_c = DW'((|operand_b) ^ negate_b);
		end else begin
			a_c = operand_a & m;
			b_c = b_n & m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_c;
			b_s1    <= b_c;
			ctrl_s1 <= '{func: func, is_bool: is_bool, mask: m};
		end
	end

endmodule

/* hdl/tilalu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilalu_div
// Restoring unsigned divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module tilalu_div import tilalu_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] a_s1,
	input  logic [DW-1:0] b_s1,
	output logic [DW-1:0] quot
);

	logic [DW-1:0] rem_s [DIV_STAGES+1];
	logic [DW-1:0] aq_s  [DIV_STAGES+1];
	logic [DW-1:0] dvs_s [DIV_STAGES+1];

	assign rem_s[0] = '0;
	assign aq_s[0]  = a_s1;
	assign dvs_s[0] = b_s1;

	// A zero divisor makes every trial subtraction succeed, so the quotient
	// comes out as all ones without a special case.
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
		logic [DW:0] sh, diff;
		logic        ge;
		always_comb begin
			sh   = {rem_s[i], aq_s[i][DW-1]};
			ge   = (sh >= {1'b0, dvs_s[i]});
			diff = sh - {1'b0, dvs_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
				aq_s[i+1]  <= {aq_s[i][DW-2:0], ge};
				dvs_s[i+1] <= dvs_s[i];
			end
		end
	end

	assign quot = aq_s[DIV_STAGES];

endmodule

/* hdl/tilalu_arith.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilalu_arith
// Logic, add, subtract, compare and split multiply, delayed to meet the divider output.
// ----------------------------------------------------------------------------
module tilalu_arith import tilalu_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] a_s1,
	input  logic [DW-1:0] b_s1,
	input  ctrl_t         ctrl_s1,
	output logic [DW-1:0] side_res,
	output ctrl_t         side_ctrl
);

	logic [DW-1:0] simple_c, simple_s2, pll_s2, mul_c;
	logic [HW-1:0] plh_c, phl_c, plh_s2, phl_s2, cross_c;
	logic [DW-1:0] pll_c;
	ctrl_t         ctrl_s2;
	logic [DW-1:0] res_d  [SIDE_DELAY+1];
	ctrl_t         ctrl_d [SIDE_DELAY+1];

	always_comb begin
		unique case (ctrl_s1.func)
			OP_AND:  simple_c = a_s1 & b_s1;
			OP_OR:   simple_c = a_s1 | b_s1;
			OP_XOR:  simple_c = a_s1 ^ b_s1;
			OP_ADD:  simple_c = a_s1 + b_s1;
			OP_SUB:  simple_c = a_s1 - b_s1;
			OP_GT:   simple_c = DW'(a_s1 > b_s1);
			OP_GE:   simple_c = DW'(a_s1 >= b_s1);
			OP_EQ:   simple_c = DW'(a_s1 == b_s1);
			OP_NE:   simple_c = DW'(a_s1 != b_s1);
			OP_LT:   simple_c = DW'(a_s1 < b_s1);
			OP_LE:   simple_c = DW'(a_s1 <= b_s1);
			default: simple_c = '0;
		endcase
		pll_c = DW'(a_s1[HW-1:0]) * DW'(b_s1[HW-1:0]);
		plh_c = a_s1[HW-1:0] * b_s1[DW-1:HW];
		phl_c = a_s1[DW-1:HW] * b_s1[HW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			simple_s2 <= simple_c;
			pll_s2    <= pll_c;
			plh_s2    <= plh_c;
			phl_s2    <= phl_c;
			ctrl_s2   <= ctrl_s1;
		end
	end

	// Only the low half of each cross product reaches the low 64 bits.
	always_comb begin
		cross_c = plh_s2 + phl_s2;
		mul_c   = pll_s2 + {cross_c, {HW{1'b0}}};
	end

	assign res_d[0]  = (ctrl_s2.func == OP_MUL) ? mul_c : simple_s2;
	assign ctrl_d[0] = ctrl_s2;

	for (genvar i = 0; i < SIDE_DELAY; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				res_d[i+1]  <= res_d[i];
				ctrl_d[i+1] <= ctrl_d[i];
			end
		end
	end

	assign side_res  = res_d[SIDE_DELAY];
	assign side_ctrl = ctrl_d[SIDE_DELAY];

endmodule

/* hdl/typed_il_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_il_alu
// Typed integer ALU of an instruction-list PLC: bitwise, arithmetic, divide
// and unsigned compare on bool, byte, word, dword and lword operands.
// ----------------------------------------------------------------------------
//
// Channel   Handshake               Payload
// request   req_valid / req_ready   func, negate_b, data_type, operand_a, operand_b
// response  rsp_valid / rsp_ready   result
//
// One request is taken every cycle while the response side does not stall.
// The pipeline depth is set by the divider, which resolves one quotient bit per stage
// over 64 stages; the other operations travel alongside in a delay line.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the response side freezes the whole pipeline at once, so no
// request is lost or repeated; req_ready falls only while a response waits.
module typed_il_alu import tilalu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [3:0]    func,
	input  logic          negate_b,
	input  logic [2:0]    data_type,
	input  logic [DW-1:0] operand_a,
	input  logic [DW-1:0] operand_b,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic [DW-1:0] result
);

	localparam int LEVELS = DIV_STAGES + 1;

	logic              en;
	logic [DW-1:0]     a_s1, b_s1, quot, side_res, final_c;
	ctrl_t             ctrl_s1, side_ctrl;
	logic [LEVELS-1:0] vld_q;

	// The pipeline moves whenever the output register is free or being drained.
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	tilalu_prep u_prep (
		.clk       (clk),
		.en        (en),
		.func      (func),
		.negate_b  (negate_b),
		.data_type (data_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.a_s1      (a_s1),
		.b_s1      (b_s1),
		.ctrl_s1   (ctrl_s1)
	);

	tilalu_div u_div (
		.clk  (clk),
		.en   (en),
		.a_s1 (a_s1),
		.b_s1 (b_s1),
		.quot (quot)
	);

	tilalu_arith u_arith (
		.clk       (clk),
		.en        (en),
		.a_s1      (a_s1),
		.b_s1      (b_s1),
		.ctrl_s1   (ctrl_s1),
		.side_res  (side_res),
		.side_ctrl (side_ctrl)
	);

	// Valid bits march with the data, one per register level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LEVELS-2:0], req_valid};
			rsp_valid <= vld_q[LEVELS-1];
		end
	end

	// Final selection: pick the quotient for a divide, cut to the type width,
	// and reduce a bool result to its truth value.
	always_comb begin
		final_c = (side_ctrl.func == OP_DIV) ? quot : side_res;
		if (side_ctrl.is_bool) begin
			final_c = DW'(|final_c);
		end else begin
			final_c = final_c & side_ctrl.mask;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= final_c;
		end
	end

endmodule

/* hdl/tilalu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilalu_checker
// Port-level checks of the typed IL ALU, bound to the top level.
// ----------------------------------------------------------------------------
module tilalu_checker import tilalu_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input logic [DW-1:0] result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result))
		else $error("response changed while stalled");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request side stalled while response side drains");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("request refused with no response waiting");

endmodule

bind typed_il_alu tilalu_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.result    (result)
);

/* tb/typed_il_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_il_alu_tb
// Self-checking bench for the typed IL integer ALU: a directed table of
// corner cases followed by random requests, with random gaps on both
// channels and one long response stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module typed_il_alu_tb import tilalu_pkg::*;;

	localparam int N_RANDOM   = 1530;
	localparam int LONG_STALL = 300;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// One row of the directed table. When has_exp is set, the typed-in value
	// is checked against the predictor as well, so that a slip in either one
	// shows up.
	typedef struct {
		logic [3:0]  fn;
		logic        neg;
		logic [2:0]  dt;
		logic [63:0] a;
		logic [63:0] b;
		logic        has_exp;
		logic [63:0] exp_val;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	logic [3:0]    func;
	logic          negate_b;
	logic [2:0]    data_type;
	logic [DW-1:0] operand_a;
	logic [DW-1:0] operand_b;
	logic          rsp_valid;
	logic          rsp_ready;
	logic [DW-1:0] result;

	logic [63:0] pending_results[$];
	int          n_errors;
	int          n_sent;
	int          n_checked;
	bit          sending_done;
	bit          long_hold;
	row_t        dir_rows[$];

	typed_il_alu dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.negate_b  (negate_b),
		.data_type (data_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.result    (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Independent model of the datapath: the bool type works on truth values,
	// every other type on masked operands with wrap-around arithmetic.
	function automatic logic [63:0] alu_result(logic [3:0] fn, logic neg, logic [2:0] dt,
			logic [63:0] a, logic [63:0] b);
		logic [63:0] width_mask;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] r;
		if (dt == TYPE_BOOL) begin
			x = {63'd0, |a};
			y = {63'd0, (|b) ^ neg};
		end else begin
			case (dt)
				TYPE_BYTE:  width_mask = 64'hFF;
				TYPE_WORD:  width_mask = 64'hFFFF;
				TYPE_DWORD: width_mask = 64'hFFFF_FFFF;
				default:    width_mask = ONES;
			endcase
			x = a & width_mask;
			y = (neg ? ~b : b) & width_mask;
		end
		case (fn)
			OP_AND: r = x & y;
			OP_OR:  r = x | y;
			OP_XOR: r = x ^ y;
			OP_ADD: r = x + y;
			OP_SUB: r = x - y;
			OP_MUL: r = x * y;
			OP_DIV: r = (y != 0) ? x / y : ONES;
			OP_GT:  r = {63'd0, x > y};
			OP_GE:  r = {63'd0, x >= y};
			OP_EQ:  r = {63'd0, x == y};
			OP_NE:  r = {63'd0, x != y};
			OP_LT:  r = {63'd0, x < y};
			OP_LE:  r = {63'd0, x <= y};
			default: r = 64'd0;
		endcase
		if (dt == TYPE_BOOL)
			return {63'd0, |r};
		return r & width_mask;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h (response %0d)", what, got, want,
			n_checked);
		n_errors++;
	endtask

	task automatic add_row(logic [3:0] fn, logic neg, logic [2:0] dt, logic [63:0] a,
			logic [63:0] b, logic has_exp, logic [63:0] exp_val);
		row_t rw;
		rw.fn = fn; rw.neg = neg; rw.dt = dt; rw.a = a; rw.b = b;
		rw.has_exp = has_exp; rw.exp_val = exp_val;
		dir_rows.push_back(rw);
	endtask

	// Random 64-bit operand, weighted towards zero, all ones and small values
	// so that divide by zero and equal compares come up often enough.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return ONES;
			2: return 64'($urandom_range(0, 3));
			3: return {32'd0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Offers one request and holds it steady until the handshake completes.
	// The expected result is queued at the moment of acceptance. Valid is
	// dropped only when an idle gap comes before the request, so that back
	// to back requests keep it high.
	task automatic send_request(logic [3:0] fn, logic neg, logic [2:0] dt, logic [63:0] a,
			logic [63:0] b);
		int gap;
		if ($urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= fn;
		negate_b  <= neg;
		data_type <= dt;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (!req_ready);
		pending_results.push_back(alu_result(fn, neg, dt, a, b));
		n_sent++;
	endtask

	// Reset and stimulus.
	initial begin
		logic [3:0] fn;
		req_valid    = 1'b0;
		func         = '0;
		negate_b     = 1'b0;
		data_type    = '0;
		operand_a    = '0;
		operand_b    = '0;
		arst_n       = 1'b0;
		n_errors     = 0;
		n_sent       = 0;
		n_checked    = 0;
		sending_done = 1'b0;

		// Extremes, every opcode and the named special cases.
		add_row(OP_AND, 0, 3'd4, ONES, ONES, 1, ONES);
		add_row(OP_OR,  0, TYPE_BYTE, 64'h0F0, 64'h10F, 1, 64'hFF);
		add_row(OP_XOR, 1, TYPE_WORD, 64'h1234, 64'h0, 1, 64'hEDCB);
		add_row(OP_ADD, 0, TYPE_BYTE, 64'hFF, 64'h1, 1, 64'h0);
		add_row(OP_ADD, 0, TYPE_BOOL, 64'h1, 64'h1, 1, 64'h1);
		add_row(OP_SUB, 0, TYPE_DWORD, 64'h0, 64'h1, 1, 64'hFFFF_FFFF);
		add_row(OP_SUB, 0, 3'd4, 64'h0, 64'h1, 1, ONES);
		add_row(OP_MUL, 0, TYPE_WORD, 64'hFFFF, 64'hFFFF, 1, 64'h1);
		add_row(OP_MUL, 0, 3'd4, ONES, ONES, 1, 64'h1);
		add_row(OP_DIV, 0, TYPE_DWORD, 64'h5, 64'h1_0000_0000, 1, 64'hFFFF_FFFF);
		add_row(OP_DIV, 0, 3'd4, ONES, 64'h0, 1, ONES);
		add_row(OP_DIV, 0, TYPE_BOOL, 64'h7, 64'h0, 1, 64'h1);
		add_row(OP_DIV, 1, TYPE_BYTE, 64'hFF, 64'hFE, 1, 64'hFF);
		add_row(OP_GT,  0, TYPE_BYTE, 64'h100, 64'h1, 1, 64'h0);
		add_row(OP_GE,  0, 3'd4, ONES, ONES, 1, 64'h1);
		add_row(OP_EQ,  1, TYPE_BOOL, 64'h0, 64'h5, 1, 64'h1);
		add_row(OP_NE,  1, TYPE_BOOL, 64'h8, 64'h0, 1, 64'h0);
		add_row(OP_LT,  0, TYPE_DWORD, 64'h8000_0000, 64'hFFFF_FFFF, 1, 64'h1);
		add_row(OP_LE,  1, TYPE_WORD, 64'hFFFF, 64'hFFFF_0000, 1, 64'h1);
		add_row(4'd13, 0, 3'd4, ONES, ONES, 1, 64'h0);
		add_row(4'd15, 1, TYPE_BOOL, 64'h1, 64'h1, 1, 64'h0);
		add_row(OP_ADD, 1, 3'd7, ONES, ONES, 0, 64'h0);
		add_row(OP_MUL, 0, 3'd5, 64'hDEAD_BEEF_0123_4567, 64'h1357_9BDF_0246_8ACE, 0, 64'h0);
		add_row(OP_DIV, 0, 3'd6, ONES, 64'h3, 0, 64'h0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp &&
				alu_result(dir_rows[i].fn, dir_rows[i].neg, dir_rows[i].dt,
					dir_rows[i].a, dir_rows[i].b) !== dir_rows[i].exp_val)
				report_mismatch("directed table entry", alu_result(dir_rows[i].fn,
					dir_rows[i].neg, dir_rows[i].dt, dir_rows[i].a, dir_rows[i].b),
					dir_rows[i].exp_val);
			send_request(dir_rows[i].fn, dir_rows[i].neg, dir_rows[i].dt,
				dir_rows[i].a, dir_rows[i].b);
		end

		// Random requests; opcodes past the last defined one turn up now and then.
		for (int i = 0; i < N_RANDOM; i++) begin
			fn = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			send_request(fn, 1'($urandom()), 3'($urandom_range(0, 7)), pick_operand(),
				pick_operand());
		end
		req_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Response side: random back-pressure, plus one long hold early in the run
	// so that the pipeline fills and req_ready drops.
	initial begin
		int gap;
		rsp_ready = 1'b0;
		long_hold = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold && n_sent > 200) begin
				long_hold = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3);
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	// Checks each accepted response against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response", result, 64'd0);
			end else begin
				if (result !== pending_results[0])
					report_mismatch("result", result, pending_results[0]);
				void'(pending_results.pop_front());
			end
			n_checked++;
		end
	end

	// Completion: drain outstanding responses, then allow the pipeline depth
	// to pass in case anything spurious comes out.
	initial begin
		wait (sending_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d responses checked, over all opcodes and types.",
			n_sent, n_checked);
		$display("Random gaps on both channels and one long response stall were applied.");
		if (n_errors == 0 && pending_results.size() == 0)
			$display("[typed_il_alu] OK");
		else
			$display("[typed_il_alu] ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("timeout after %0d responses", n_checked);
		$display("[typed_il_alu] ERROR");
		$finish;
	end

endmodule
